@@ hw/rtl/tcce_pkg.sv @@
// Shared constants, result type and palette/pixel packing functions for the console cursor engine.
package tcce_pkg;

  // Configuration register indexes.
  localparam logic [2:0] REG_TEXT_COLUMNS = 3'd0;
  localparam logic [2:0] REG_TEXT_ROWS    = 3'd1;
  localparam logic [2:0] REG_RED_SHIFT    = 3'd2;
  localparam logic [2:0] REG_RED_BITS     = 3'd3;
  localparam logic [2:0] REG_GREEN_SHIFT  = 3'd4;
  localparam logic [2:0] REG_GREEN_BITS   = 3'd5;
  localparam logic [2:0] REG_BLUE_SHIFT   = 3'd6;
  localparam logic [2:0] REG_BLUE_BITS    = 3'd7;

  // Register reset values.
  localparam logic [8:0] RST_TEXT_COLUMNS = 9'd80;
  localparam logic [7:0] RST_TEXT_ROWS    = 8'd25;
  localparam logic [4:0] RST_RED_SHIFT    = 5'd16;
  localparam logic [3:0] RST_RED_BITS     = 4'd8;
  localparam logic [4:0] RST_GREEN_SHIFT  = 5'd8;
  localparam logic [3:0] RST_GREEN_BITS   = 4'd8;
  localparam logic [4:0] RST_BLUE_SHIFT   = 5'd0;
  localparam logic [3:0] RST_BLUE_BITS    = 4'd8;

  // Command codes.
  localparam logic [1:0] CMD_PUT_CHAR     = 2'd0;
  localparam logic [1:0] CMD_SET_COLOR    = 2'd1;
  localparam logic [1:0] CMD_RESET_COLOR  = 2'd2;
  localparam logic [1:0] CMD_CLEAR_SCREEN = 2'd3;

  // Action codes.
  localparam logic [1:0] ACT_DRAW         = 2'd0;
  localparam logic [1:0] ACT_CLEAR_CELL   = 2'd1;
  localparam logic [1:0] ACT_SCROLL       = 2'd2;
  localparam logic [1:0] ACT_CLEAR_SCREEN = 2'd3;

  // Character codes with special handling.
  localparam logic [7:0] CH_BACKSPACE = 8'h08;
  localparam logic [7:0] CH_TAB       = 8'h09;
  localparam logic [7:0] CH_NEWLINE   = 8'h0A;
  localparam logic [7:0] CH_RETURN    = 8'h0D;
  localparam logic [6:0] GLYPH_SUBST  = 7'h3F;

  // Color state after reset.
  localparam logic [3:0] FG_RESET = 4'd7;
  localparam logic [3:0] BG_RESET = 4'd0;

  // Default geometry limits and tab spacing.
  localparam int DEF_MAX_COLS = 256;
  localparam int DEF_MAX_ROWS = 128;
  localparam int DEF_TAB_STOP = 8;

  // One queued action.
  typedef struct packed {
    logic [1:0] action;
    logic [7:0] col;
    logic [6:0] row;
    logic [6:0] glyph;
  } result_t;

  // Sixteen-color palette as {red, green, blue}.
  function automatic logic [23:0] palette(input logic [3:0] idx);
    logic [23:0] rgb;
    case (idx)
      4'd0:    rgb = 24'h000000;
      4'd1:    rgb = 24'h0000AA;
      4'd2:    rgb = 24'h00AA00;
      4'd3:    rgb = 24'h00AAAA;
      4'd4:    rgb = 24'hAA0000;
      4'd5:    rgb = 24'hAA00AA;
      4'd6:    rgb = 24'hAA5500;
      4'd7:    rgb = 24'hAAAAAA;
      4'd8:    rgb = 24'h555555;
      4'd9:    rgb = 24'h5555FF;
      4'd10:   rgb = 24'h55FF55;
      4'd11:   rgb = 24'h55FFFF;
      4'd12:   rgb = 24'hFF5555;
      4'd13:   rgb = 24'hFF55FF;
      4'd14:   rgb = 24'hFFFF55;
      default: rgb = 24'hFFFFFF;
    endcase
    return rgb;
  endfunction

  // One color channel: keep the top bits of the 8-bit value and place them at shift.
  function automatic logic [31:0] chan(input logic [7:0] c, input logic [4:0] shift,
                                       input logic [3:0] bits);
    logic [3:0] b;
    logic [7:0] top;
    b = (bits > 4'd8) ? 4'd8 : bits;
    top = c >> (4'd8 - b);
    if (bits == 4'd0) begin
      return 32'd0;
    end
    return {24'd0, top} << shift;
  endfunction

  // Packed pixel word for a palette index.
  function automatic logic [31:0] pack(input logic [3:0] idx,
                                       input logic [4:0] rs, input logic [3:0] rb,
                                       input logic [4:0] gs, input logic [3:0] gb,
                                       input logic [4:0] bs, input logic [3:0] bb);
    logic [23:0] rgb;
    rgb = palette(idx);
    return chan(rgb[23:16], rs, rb) | chan(rgb[15:8], gs, gb) | chan(rgb[7:0], bs, bb);
  endfunction

endpackage

@@ hw/rtl/text_console_cursor_engine_unit.sv @@
// Console cursor engine: command decode, cursor update and a three-entry action queue.
//
// Usage: commands enter on the in_valid/in_ready channel (cmd, char_code, attr).
// Each accepted beat updates the cursor and color state in the same cycle and
// loads the zero to three actions it causes into the output queue, each with
// the packed foreground and background pixels. Actions leave on the
// out_valid/out_ready channel in order; last marks the final action of a command.
// The first action of a command is on the output in the cycle after the
// command beat. Throughput: one command per cycle while each command gives at
// most one action and the receiver takes every action; a command with more
// actions holds in_ready low while the single output port drains its queue one beat per cycle.
// A command is taken in the cycle its predecessor's final action leaves.
// A stalled receiver keeps the queue and therefore the input channel waiting.
// Configuration writes on cfg_valid/cfg_index/cfg_data are always taken
// (cfg_ready is high) and are meant for idle periods only.
// Reset empties the queue, homes the cursor, restores the default colors
// (foreground 7, background 0) and the default geometry and pixel layout.
module text_console_cursor_engine_unit #(
  parameter int MAX_COLS = tcce_pkg::DEF_MAX_COLS,
  parameter int MAX_ROWS = tcce_pkg::DEF_MAX_ROWS,
  parameter int TAB_STOP = tcce_pkg::DEF_TAB_STOP
) (
  input  logic        clk,
  input  logic        rst,
  // Command channel.
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  cmd,
  input  logic [7:0]  char_code,
  input  logic [7:0]  attr,
  // Action channel.
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  action,
  output logic [7:0]  cell_col,
  output logic [6:0]  cell_row,
  output logic [6:0]  glyph_code,
  output logic [31:0] fg_pixel,
  output logic [31:0] bg_pixel,
  output logic        last,
  // Configuration write channel.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [8:0]  cfg_data
);

  localparam int COL_W = $clog2(MAX_COLS + 1);
  localparam int ROW_W = $clog2(MAX_ROWS + 1);
  // Working widths cover both the cursor and the raw geometry registers.
  localparam int CW  = (COL_W > 9) ? COL_W : 9;
  localparam int RWX = (ROW_W > 8) ? ROW_W : 8;
  localparam int NW  = CW + 1;
  // Reciprocal of the tab spacing for the column-to-tab-stop division.
  localparam int SH    = CW + 5;
  localparam int RECIP = (2 ** SH) / TAB_STOP;

  // Configuration registers.
  logic [8:0] text_columns;
  logic [7:0] text_rows;
  logic [4:0] red_shift;
  logic [3:0] red_bits;
  logic [4:0] green_shift;
  logic [3:0] green_bits;
  logic [4:0] blue_shift;
  logic [3:0] blue_bits;

  // Cursor and color state.
  logic [COL_W-1:0] cursor_col;
  logic [ROW_W-1:0] cursor_row;
  logic [3:0]       fg_index;
  logic [3:0]       bg_index;

  // Action queue, head in slot0.
  tcce_pkg::result_t slot0, slot1, slot2;
  logic [1:0]        cnt;
  logic [31:0]       fg_pix;
  logic [31:0]       bg_pix;

  // Next-state values from the command decode.
  logic [CW-1:0]     cols_eff;
  logic [RWX-1:0]    rows_eff;
  logic [CW-1:0]     col_next;
  logic [RWX-1:0]    row_next;
  logic [3:0]        fg_next;
  logic [3:0]        bg_next;
  logic [1:0]        n;
  tcce_pkg::result_t ent0, ent1, ent2;

  logic in_fire;
  logic out_fire;

  assign cfg_ready = 1'b1;
  assign out_valid = (cnt != 2'd0);
  assign out_fire  = out_valid && out_ready;
  // The queue is free when empty or when its final beat leaves this cycle.
  assign in_ready  = (cnt == 2'd0) || ((cnt == 2'd1) && out_ready);
  assign in_fire   = in_valid && in_ready;

  // Effective geometry: zero acts as one, large values saturate at the maximum.
  always_comb begin
    if (text_columns == 9'd0) begin
      cols_eff = CW'(1);
    end else if (CW'(text_columns) > CW'(MAX_COLS)) begin
      cols_eff = CW'(MAX_COLS);
    end else begin
      cols_eff = CW'(text_columns);
    end
    if (text_rows == 8'd0) begin
      rows_eff = RWX'(1);
    end else if (RWX'(text_rows) > RWX'(MAX_ROWS)) begin
      rows_eff = RWX'(MAX_ROWS);
    end else begin
      rows_eff = RWX'(text_rows);
    end
  end

  // Command decode and cursor movement.
  always_comb begin
    logic [CW-1:0]      c0;
    logic [RWX-1:0]     r0;
    logic [RWX-1:0]     bottom_row;
    logic [1:0]         nl_act;
    logic [CW+SH-1:0]   tab_prod;
    logic [CW-1:0]      tab_q;
    logic [CW-1:0]      tab_mul;
    logic [CW-1:0]      tab_rem;
    logic [CW-1:0]      tab_rem_adj;
    logic [NW-1:0]      tab_next;
    logic [CW-1:0]      col_d;
    logic [RWX-1:0]     row_d;
    logic [CW-1:0]      col_a;
    logic [6:0]         glyph;
    logic               pre_v, mid_v, post_v;
    tcce_pkg::result_t  pre_e, mid_e, post_e;

    // Pull an off-screen cursor back inside the current geometry.
    r0 = (RWX'(cursor_row) >= rows_eff) ? rows_eff - RWX'(1) : RWX'(cursor_row);
    c0 = (CW'(cursor_col) > cols_eff) ? cols_eff : CW'(cursor_col);
    bottom_row = rows_eff - RWX'(1);
    // A newline on the bottom row scrolls, or clears a one-row screen.
    nl_act = (rows_eff <= RWX'(1)) ? tcce_pkg::ACT_CLEAR_SCREEN : tcce_pkg::ACT_SCROLL;

    // Next tab stop: quotient by reciprocal, remainder corrected once.
    tab_prod    = {{SH{1'b0}}, c0} * (CW+SH)'(RECIP);
    tab_q       = tab_prod[CW+SH-1:SH];
    tab_mul     = tab_q * CW'(TAB_STOP);
    tab_rem     = c0 - tab_mul;
    tab_rem_adj = (tab_rem >= CW'(TAB_STOP)) ? tab_rem - CW'(TAB_STOP) : tab_rem;
    tab_next    = {1'b0, c0} + NW'(TAB_STOP) - {1'b0, tab_rem_adj};

    glyph = char_code[7] ? tcce_pkg::GLYPH_SUBST : char_code[6:0];

    col_next = c0;
    row_next = r0;
    fg_next  = fg_index;
    bg_next  = bg_index;
    pre_v    = 1'b0;
    mid_v    = 1'b0;
    post_v   = 1'b0;
    pre_e    = '{action: nl_act, col: 8'd0, row: 7'd0, glyph: 7'd0};
    mid_e    = '{action: nl_act, col: 8'd0, row: 7'd0, glyph: 7'd0};
    post_e   = '{action: nl_act, col: 8'd0, row: 7'd0, glyph: 7'd0};
    col_d    = c0;
    row_d    = r0;
    col_a    = c0 + CW'(1);

    case (cmd)
      tcce_pkg::CMD_PUT_CHAR: begin
        case (char_code)
          tcce_pkg::CH_NEWLINE: begin
            col_next = '0;
            if (r0 == bottom_row) begin
              mid_v = 1'b1;
            end else begin
              row_next = r0 + RWX'(1);
            end
          end
          tcce_pkg::CH_RETURN: begin
            col_next = '0;
          end
          tcce_pkg::CH_TAB: begin
            if (tab_next >= {1'b0, cols_eff}) begin
              col_next = '0;
              if (r0 == bottom_row) begin
                mid_v = 1'b1;
              end else begin
                row_next = r0 + RWX'(1);
              end
            end else begin
              col_next = tab_next[CW-1:0];
            end
          end
          tcce_pkg::CH_BACKSPACE: begin
            if (c0 != '0) begin
              col_next = c0 - CW'(1);
              mid_v    = 1'b1;
              mid_e    = '{action: tcce_pkg::ACT_CLEAR_CELL, col: col_next[7:0],
                           row: r0[6:0], glyph: 7'd0};
            end
          end
          default: begin
            // Wrap before the draw when the cursor sits past the last column.
            if (c0 >= cols_eff) begin
              col_d = '0;
              if (r0 == bottom_row) begin
                pre_v = 1'b1;
                row_d = r0;
              end else begin
                row_d = r0 + RWX'(1);
              end
            end
            mid_v = 1'b1;
            mid_e = '{action: tcce_pkg::ACT_DRAW, col: col_d[7:0], row: row_d[6:0],
                      glyph: glyph};
            col_a = col_d + CW'(1);
            // Wrap after the draw when the column reaches the limit.
            if (col_a >= cols_eff) begin
              col_next = '0;
              if (row_d == bottom_row) begin
                post_v   = 1'b1;
                row_next = row_d;
              end else begin
                row_next = row_d + RWX'(1);
              end
            end else begin
              col_next = col_a;
              row_next = row_d;
            end
          end
        endcase
      end
      tcce_pkg::CMD_SET_COLOR: begin
        fg_next = attr[3:0];
        bg_next = attr[7:4];
      end
      tcce_pkg::CMD_RESET_COLOR: begin
        fg_next = tcce_pkg::FG_RESET;
        bg_next = tcce_pkg::BG_RESET;
      end
      default: begin
        mid_v    = 1'b1;
        mid_e    = '{action: tcce_pkg::ACT_CLEAR_SCREEN, col: 8'd0, row: 7'd0, glyph: 7'd0};
        col_next = '0;
        row_next = '0;
      end
    endcase

    // Pack the actions in order; a leading wrap is only ever followed by a draw.
    n = 2'(pre_v) + 2'(mid_v) + 2'(post_v);
    if (pre_v) begin
      ent0 = pre_e;
      ent1 = mid_e;
      ent2 = post_e;
    end else begin
      ent0 = mid_e;
      ent1 = post_e;
      ent2 = post_e;
    end
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      text_columns <= tcce_pkg::RST_TEXT_COLUMNS;
      text_rows    <= tcce_pkg::RST_TEXT_ROWS;
      red_shift    <= tcce_pkg::RST_RED_SHIFT;
      red_bits     <= tcce_pkg::RST_RED_BITS;
      green_shift  <= tcce_pkg::RST_GREEN_SHIFT;
      green_bits   <= tcce_pkg::RST_GREEN_BITS;
      blue_shift   <= tcce_pkg::RST_BLUE_SHIFT;
      blue_bits    <= tcce_pkg::RST_BLUE_BITS;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        tcce_pkg::REG_TEXT_COLUMNS: text_columns <= cfg_data;
        tcce_pkg::REG_TEXT_ROWS:    text_rows    <= cfg_data[7:0];
        tcce_pkg::REG_RED_SHIFT:    red_shift    <= cfg_data[4:0];
        tcce_pkg::REG_RED_BITS:     red_bits     <= cfg_data[3:0];
        tcce_pkg::REG_GREEN_SHIFT:  green_shift  <= cfg_data[4:0];
        tcce_pkg::REG_GREEN_BITS:   green_bits   <= cfg_data[3:0];
        tcce_pkg::REG_BLUE_SHIFT:   blue_shift   <= cfg_data[4:0];
        default:                    blue_bits    <= cfg_data[3:0];
      endcase
    end
  end

  // Cursor and color state.
  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_col <= '0;
      cursor_row <= '0;
      fg_index   <= tcce_pkg::FG_RESET;
      bg_index   <= tcce_pkg::BG_RESET;
    end else if (in_fire) begin
      cursor_col <= col_next[COL_W-1:0];
      cursor_row <= row_next[ROW_W-1:0];
      fg_index   <= fg_next;
      bg_index   <= bg_next;
    end
  end

  // Queue occupancy.
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else if (in_fire) begin
      cnt <= n;
    end else if (out_fire) begin
      cnt <= cnt - 2'd1;
    end
  end

  // Queue payload: load on a command beat, shift toward the head on each output beat.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      slot0  <= ent0;
      slot1  <= ent1;
      slot2  <= ent2;
      fg_pix <= tcce_pkg::pack(fg_index, red_shift, red_bits, green_shift, green_bits,
                               blue_shift, blue_bits);
      bg_pix <= tcce_pkg::pack(bg_index, red_shift, red_bits, green_shift, green_bits,
                               blue_shift, blue_bits);
    end else if (out_fire) begin
      slot0 <= slot1;
      slot1 <= slot2;
    end
  end

  assign action     = slot0.action;
  assign cell_col   = slot0.col;
  assign cell_row   = slot0.row;
  assign glyph_code = slot0.glyph;
  assign fg_pixel   = fg_pix;
  assign bg_pixel   = bg_pix;
  assign last       = (cnt == 2'd1);

`ifndef SYNTH
  // The queue holds exactly the actions decoded for the last command beat.
  assert property (@(posedge clk) disable iff (rst)
    in_fire |=> (cnt == $past(n)))
    else $error("action queue count differs from decoded action count");

  // The cursor row stays on screen after every command.
  assert property (@(posedge clk) disable iff (rst)
    in_fire |=> (RWX'(cursor_row) < $past(rows_eff)))
    else $error("cursor row left the screen");

  // The cursor column never passes the column limit.
  assert property (@(posedge clk) disable iff (rst)
    in_fire |=> (CW'(cursor_col) <= $past(cols_eff)))
    else $error("cursor column beyond the column limit");

  // Scroll and clear-screen actions carry no cell and no glyph.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && (action == tcce_pkg::ACT_SCROLL || action == tcce_pkg::ACT_CLEAR_SCREEN))
      |-> (cell_col == 8'd0 && cell_row == 7'd0 && glyph_code == 7'd0))
    else $error("whole-screen action carries cell fields");
`endif

endmodule
